// ===== sv/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class preferential queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int Capacity = 16;
  localparam int IdW      = 16;
  localparam int CountW   = 5;

  typedef enum logic [1:0] {
    OP_INSERT       = 2'd0,
    OP_SERVE_PREF   = 2'd1,
    OP_SERVE_OLDEST = 2'd2,
    OP_WITHDRAW     = 2'd3
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [IdW-1:0] id;
    logic           preferential;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [IdW-1:0]    served_id;
    logic [CountW-1:0] total_count;
    logic [CountW-1:0] pref_count;
  } rsp_t;

  // one queue entry, kept in arrival order in the entry memory
  typedef struct packed {
    logic           pref;
    logic [IdW-1:0] id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_SHIFT,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/tcpq_stream_if.sv =====
// ----------------------------------------------------------------------------
// tcpq_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tcpq_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/tcpq_mem.sv =====
// ----------------------------------------------------------------------------
// tcpq_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcpq_mem #(
  parameter int CAPACITY = tcpq_pkg::Capacity
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output tcpq_pkg::entry_t            rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  tcpq_pkg::entry_t            wr_data
);

  tcpq_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer: scans the entry memory, appends, compacts and forms the result.
// ----------------------------------------------------------------------------
module tcpq_ctrl #(
  parameter int CAPACITY = tcpq_pkg::Capacity
) (
  input  logic                        clk,
  input  logic                        rst,
  tcpq_stream_if.sink                 req,
  tcpq_stream_if.source               rsp,
  output logic                        mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
  input  tcpq_pkg::entry_t            mem_rd_data,
  output logic                        mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
  output tcpq_pkg::entry_t            mem_wr_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  tcpq_pkg::state_t state, state_next;

  tcpq_pkg::op_t                op;
  logic [tcpq_pkg::IdW-1:0]     id;
  logic                         pref;
  logic [CW-1:0]                occ;
  logic [CW-1:0]                pcnt;
  logic [CW-1:0]                ptr;
  logic                         rd_valid;
  logic [CW-1:0]                rd_pos;
  tcpq_pkg::entry_t             head;
  logic                         rem_pref;
  logic [tcpq_pkg::IdW-1:0]     served;
  logic                         ok;
  logic                         rsp_valid;
  tcpq_pkg::rsp_t               rsp_data;

  logic          accept;
  logic          match;
  logic          hit;
  logic          issue;
  logic          scan_end;
  logic          shift_end;
  logic          load_rsp;
  logic          is_serve;
  logic          reject;
  logic [CW-1:0] wr_pos;

  always_comb begin
    accept   = req.valid && req.ready;
    is_serve = (op == tcpq_pkg::OP_SERVE_PREF) || (op == tcpq_pkg::OP_SERVE_OLDEST);
    unique case (op)
      tcpq_pkg::OP_INSERT,
      tcpq_pkg::OP_WITHDRAW:     match = (mem_rd_data.id == id);
      tcpq_pkg::OP_SERVE_PREF:   match = mem_rd_data.pref;
      tcpq_pkg::OP_SERVE_OLDEST: match = 1'b1;
      default:                   match = 1'b0;
    endcase
    hit       = (state == tcpq_pkg::ST_SCAN) && rd_valid && match;
    issue     = ((state == tcpq_pkg::ST_SCAN) && !hit && (ptr < occ)) ||
                ((state == tcpq_pkg::ST_SHIFT) && (ptr < occ));
    scan_end  = (state == tcpq_pkg::ST_SCAN) && !rd_valid && (ptr >= occ);
    shift_end = (state == tcpq_pkg::ST_SHIFT) && !rd_valid && (ptr >= occ);
    load_rsp  = (state == tcpq_pkg::ST_FINISH) && (!rsp_valid || rsp.ready);
    // full insert or empty serve fails without touching the memory
    reject    = ((req.data.op == tcpq_pkg::OP_INSERT) && (occ == CW'(CAPACITY))) ||
                (((req.data.op == tcpq_pkg::OP_SERVE_PREF) ||
                  (req.data.op == tcpq_pkg::OP_SERVE_OLDEST)) && (occ == '0));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcpq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = reject ? tcpq_pkg::ST_FINISH : tcpq_pkg::ST_SCAN;
        end
      end
      tcpq_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = (op == tcpq_pkg::OP_INSERT) ? tcpq_pkg::ST_FINISH
                                                   : tcpq_pkg::ST_SHIFT;
        end else if (scan_end) begin
          unique case (op)
            tcpq_pkg::OP_INSERT:     state_next = tcpq_pkg::ST_INSERT;
            tcpq_pkg::OP_SERVE_PREF: state_next = tcpq_pkg::ST_SHIFT;
            default:                 state_next = tcpq_pkg::ST_FINISH;
          endcase
        end
      end
      tcpq_pkg::ST_INSERT: state_next = tcpq_pkg::ST_FINISH;
      tcpq_pkg::ST_SHIFT: begin
        if (shift_end) begin
          state_next = tcpq_pkg::ST_FINISH;
        end
      end
      tcpq_pkg::ST_FINISH: begin
        if (load_rsp) begin
          state_next = tcpq_pkg::ST_IDLE;
        end
      end
      default: state_next = tcpq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    wr_pos      = rd_pos - CW'(1);
    req.ready   = (state == tcpq_pkg::ST_IDLE);
    mem_rd_en   = issue;
    mem_rd_addr = ptr[AW-1:0];
    mem_wr_en   = ((state == tcpq_pkg::ST_SHIFT) && rd_valid) ||
                  (state == tcpq_pkg::ST_INSERT);
    if (state == tcpq_pkg::ST_INSERT) begin
      mem_wr_addr = occ[AW-1:0];
      mem_wr_data = '{pref: pref, id: id};
    end else begin
      // compaction moves entry k+1 down to k
      mem_wr_addr = wr_pos[AW-1:0];
      mem_wr_data = mem_rd_data;
    end
    rsp.valid = rsp_valid;
    rsp.data  = rsp_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcpq_pkg::ST_IDLE;
      occ       <= '0;
      pcnt      <= '0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (issue) begin
        rd_pos <= ptr;
        ptr    <= ptr + CW'(1);
      end
      unique case (state)
        tcpq_pkg::ST_IDLE: begin
          if (accept) begin
            op     <= req.data.op;
            id     <= req.data.id;
            pref   <= req.data.preferential;
            ptr    <= '0;
            ok     <= 1'b0;
            served <= '0;
          end
        end
        tcpq_pkg::ST_SCAN: begin
          if (rd_valid && (rd_pos == '0)) begin
            head <= mem_rd_data;
          end
          if (hit && (op != tcpq_pkg::OP_INSERT)) begin
            served   <= is_serve ? mem_rd_data.id : '0;
            rem_pref <= mem_rd_data.pref;
            ptr      <= rd_pos + CW'(1);
          end else if (scan_end && (op == tcpq_pkg::OP_SERVE_PREF)) begin
            // no preferential entry: serve the head
            served   <= head.id;
            rem_pref <= head.pref;
            ptr      <= CW'(1);
          end
        end
        tcpq_pkg::ST_INSERT: begin
          occ  <= occ + CW'(1);
          pcnt <= pcnt + CW'(pref);
          ok   <= 1'b1;
        end
        tcpq_pkg::ST_SHIFT: begin
          if (shift_end) begin
            occ  <= occ - CW'(1);
            pcnt <= pcnt - CW'(rem_pref);
            ok   <= 1'b1;
          end
        end
        tcpq_pkg::ST_FINISH: ;
        default: ;
      endcase
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_data <= '{ok:          ok,
                    served_id:   served,
                    total_count: tcpq_pkg::CountW'(occ),
                    pref_count:  tcpq_pkg::CountW'(pcnt)};
    end
  end

endmodule

// ===== sv/two_class_preferential_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_preferential_queue
// Bounded arrival-ordered queue of unique ids in two classes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command item {op, id, preferential}: insert, serve the
//   oldest preferential entry (or the oldest entry), serve the oldest entry,
//   or withdraw a named id. rsp returns exactly one item per command:
//   {ok, served_id, total_count, pref_count}, counts taken after the command.
//   Entries live in arrival order in a single-port-read entry memory with
//   registered read data. A command scans that memory one entry per cycle
//   and a removal compacts the entries behind it one per cycle. The shortest
//   command is a rejected insert or empty serve, which skips the memory; the
//   longest is a preferential serve that finds no preferential entry in a
//   full queue: a full scan, then compaction of all but the head. The scan
//   and compaction through the memory read port set how long a command
//   takes. Commands are taken one at a time; req.ready is high while no
//   command is in progress. The result sits in an output register, so a
//   new command is accepted and worked on while the previous result waits
//   on a stalled rsp.ready; only the hand-off of the next result waits for
//   the register to free.
//   Synchronous reset empties the queue and drops any pending result; the
//   memory itself is not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
module two_class_preferential_queue #(
  parameter int CAPACITY = tcpq_pkg::Capacity
) (
  input  logic          clk,
  input  logic          rst,
  tcpq_stream_if.sink   req,
  tcpq_stream_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  tcpq_pkg::entry_t mem_rd_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  tcpq_pkg::entry_t mem_wr_data;

  tcpq_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  tcpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

// ===== sv/tcpq_chk.sv =====
// ----------------------------------------------------------------------------
// tcpq_chk
// Port-level checks of the preferential queue, bound to the top level.
// ----------------------------------------------------------------------------
module tcpq_chk #(
  parameter int CAPACITY = tcpq_pkg::Capacity
) (
  input logic           clk,
  input logic           rst,
  tcpq_stream_if.sink   req,
  tcpq_stream_if.source rsp
);

  // reset drops any pending result
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result pending after reset");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("stalled result changed");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("command accepted while busy");

  // a failed command serves nothing
  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.ok |-> rsp.data.served_id == '0)
    else $error("served id on failed command");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (CAPACITY > 31) ||
      ((rsp.data.pref_count <= rsp.data.total_count) &&
       (rsp.data.total_count <= tcpq_pkg::CountW'(CAPACITY))))
    else $error("queue counts out of range");

endmodule

bind two_class_preferential_queue tcpq_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
